/* rtl/rbsi_pkg.sv */
// Shared types, constants and saturation helpers for the ray/box slab test.
// No dependencies.
package rbsi_pkg;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int QB = CW - 1;
  localparam int NW = CW + 1 + FB;
  localparam int TW = 17;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [TW-1:0] thr_t;

  localparam coord_t CMAX = coord_t'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam coord_t CMIN = coord_t'(-(64'sd1 <<< (CW - 1)));
  localparam thr_t THR_RESET = thr_t'(8);

  function automatic coord_t sat35(input logic signed [34:0] v);
    coord_t r;
    if (v > 35'(CMAX)) r = CMAX;
    else if (v < 35'(CMIN)) r = CMIN;
    else r = v[CW-1:0];
    return r;
  endfunction

  function automatic coord_t sat65(input logic signed [64:0] v);
    coord_t r;
    if (v > 65'(CMAX)) r = CMAX;
    else if (v < 65'(CMIN)) r = CMIN;
    else r = v[CW-1:0];
    return r;
  endfunction

endpackage

/* rtl/ray_box_slab_intersection.sv */
// Top level of the 2D ray against axis-aligned box slab test.
// Depends on rbsi_pkg and rbsi_div.
// One word per cycle while no result waits under stall.
// The four slab distances go through 32-stage bit-per-stage dividers.
// The whole pipeline holds while a result waits under stall.
// Synchronous reset clears valid bits and sets the threshold to 8.
module ray_box_slab_intersection (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  rbsi_pkg::coord_t          box_pos_x,
  input  rbsi_pkg::coord_t          box_pos_y,
  input  rbsi_pkg::coord_t          box_offset_x,
  input  rbsi_pkg::coord_t          box_offset_y,
  input  logic [30:0]               box_size_x,
  input  logic [30:0]               box_size_y,
  input  rbsi_pkg::coord_t          origin_x,
  input  rbsi_pkg::coord_t          origin_y,
  input  rbsi_pkg::coord_t          dir_x,
  input  rbsi_pkg::coord_t          dir_y,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      hit,
  output rbsi_pkg::coord_t          hit_x,
  output rbsi_pkg::coord_t          hit_y,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  rbsi_pkg::thr_t            cfg_data
);

  localparam int CW = rbsi_pkg::CW;
  localparam int FB = rbsi_pkg::FB;
  localparam int DL = rbsi_pkg::QB + 1;

  typedef struct packed {
    logic             par_x;
    logic             in_x;
    logic             par_y;
    logic             in_y;
    rbsi_pkg::coord_t ox;
    rbsi_pkg::coord_t oy;
    rbsi_pkg::coord_t dx;
    rbsi_pkg::coord_t dy;
  } side_t;

  logic en;
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  rbsi_pkg::thr_t thr;
  always_ff @(posedge clk) begin
    if (rst) thr <= rbsi_pkg::THR_RESET;
    else if (cfg_valid) thr <= cfg_data;
  end

  // stage 0: input word
  logic v0;
  rbsi_pkg::coord_t px, py, fx, fy, ox0, oy0, dx0, dy0;
  logic [30:0] szx, szy;
  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= in_valid;
    if (en) begin
      px <= box_pos_x;     py <= box_pos_y;
      fx <= box_offset_x;  fy <= box_offset_y;
      szx <= box_size_x;   szy <= box_size_y;
      ox0 <= origin_x;     oy0 <= origin_y;
      dx0 <= dir_x;        dy0 <= dir_y;
    end
  end

  // stage 1: box bounds
  logic v1;
  rbsi_pkg::coord_t lox, hix, loy, hiy, ox1, oy1, dx1, dy1;
  logic signed [34:0] sx, sy;
  assign sx = 35'(px) + 35'(fx);
  assign sy = 35'(py) + 35'(fy);
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= v0;
    if (en) begin
      lox <= rbsi_pkg::sat35(sx);
      loy <= rbsi_pkg::sat35(sy);
      hix <= rbsi_pkg::sat35(sx + $signed({4'b0, szx}));
      hiy <= rbsi_pkg::sat35(sy + $signed({4'b0, szy}));
      ox1 <= ox0; oy1 <= oy0; dx1 <= dx0; dy1 <= dy0;
    end
  end

  // stage 2: slab numerators, parallel and inside flags
  logic v2;
  logic signed [CW:0] nlx, nhx, nly, nhy;
  side_t s2;
  logic [CW-1:0] amx, amy;
  assign amx = dx1[CW-1] ? CW'(-dx1) : dx1;
  assign amy = dy1[CW-1] ? CW'(-dy1) : dy1;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      nlx <= (CW+1)'(lox) - (CW+1)'(ox1);
      nhx <= (CW+1)'(hix) - (CW+1)'(ox1);
      nly <= (CW+1)'(loy) - (CW+1)'(oy1);
      nhy <= (CW+1)'(hiy) - (CW+1)'(oy1);
      s2.par_x <= amx < CW'(thr);
      s2.par_y <= amy < CW'(thr);
      s2.in_x  <= !(ox1 < lox || ox1 > hix);
      s2.in_y  <= !(oy1 < loy || oy1 > hiy);
      s2.ox <= ox1; s2.oy <= oy1; s2.dx <= dx1; s2.dy <= dy1;
    end
  end

  rbsi_pkg::coord_t t_lx, t_hx, t_ly, t_hy;
  rbsi_div u_div_lx (.clk(clk), .en(en), .num(nlx), .den(s2.dx), .quo(t_lx));
  rbsi_div u_div_hx (.clk(clk), .en(en), .num(nhx), .den(s2.dx), .quo(t_hx));
  rbsi_div u_div_ly (.clk(clk), .en(en), .num(nly), .den(s2.dy), .quo(t_ly));
  rbsi_div u_div_hy (.clk(clk), .en(en), .num(nhy), .den(s2.dy), .quo(t_hy));

  logic  vd [0:DL-1];
  side_t sd [0:DL-1];
  always_ff @(posedge clk) begin
    if (rst) vd[0] <= 1'b0;
    else if (en) vd[0] <= v2;
    if (en) sd[0] <= s2;
  end
  for (genvar k = 1; k < DL; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (rst) vd[k] <= 1'b0;
      else if (en) vd[k] <= vd[k-1];
      if (en) sd[k] <= sd[k-1];
    end
  end

  // stage A: order entry and exit per axis
  logic va;
  side_t sa;
  rbsi_pkg::coord_t t1x, t2x, t1y, t2y;
  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else if (en) va <= vd[DL-1];
    if (en) begin
      sa  <= sd[DL-1];
      t1x <= (t_lx > t_hx) ? t_hx : t_lx;
      t2x <= (t_lx > t_hx) ? t_lx : t_hx;
      t1y <= (t_ly > t_hy) ? t_hy : t_ly;
      t2y <= (t_ly > t_hy) ? t_ly : t_hy;
    end
  end

  // stage B: interval narrowing
  logic vb, hb;
  side_t sb;
  rbsi_pkg::coord_t near_b;
  rbsi_pkg::coord_t n1, n2, f1, f2;
  always_comb begin
    n1 = (!sa.par_x && t1x > 0) ? t1x : '0;
    f1 = sa.par_x ? rbsi_pkg::CMAX : t2x;
    n2 = (!sa.par_y && t1y > n1) ? t1y : n1;
    f2 = (!sa.par_y && t2y < f1) ? t2y : f1;
  end
  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else if (en) vb <= va;
    if (en) begin
      sb     <= sa;
      near_b <= n2;
      hb     <= (!sa.par_x || sa.in_x) && (!sa.par_y || sa.in_y) && (n2 <= f2);
    end
  end

  // stage C: direction times near distance
  logic vc, hc;
  rbsi_pkg::coord_t oxc, oyc;
  logic signed [2*CW-1:0] prx, pry;
  always_ff @(posedge clk) begin
    if (rst) vc <= 1'b0;
    else if (en) vc <= vb;
    if (en) begin
      hc  <= hb;
      oxc <= sb.ox;
      oyc <= sb.oy;
      prx <= sb.dx * near_b;
      pry <= sb.dy * near_b;
    end
  end

  // output: truncate toward zero, add origin, saturate
  logic signed [64:0] ex, ey;
  always_comb begin
    ex = 65'(oxc) + 65'($signed(prx + (prx[2*CW-1] ? (2*CW)'((1 << FB) - 1) : '0)) >>> FB);
    ey = 65'(oyc) + 65'($signed(pry + (pry[2*CW-1] ? (2*CW)'((1 << FB) - 1) : '0)) >>> FB);
  end
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= vc;
    if (en) begin
      hit   <= hc;
      hit_x <= hc ? rbsi_pkg::sat65(ex) : '0;
      hit_y <= hc ? rbsi_pkg::sat65(ey) : '0;
    end
  end

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> hit_x == '0 && hit_y == '0)
    else $error("miss result carries non-zero position");

  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> thr == $past(cfg_data))
    else $error("threshold not taken from write");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result word valid straight after reset");

endmodule

/* rtl/rbsi_div.sv */
// Pipelined saturating fixed-point divider: num * 2^FB / den, truncated, one
// quotient bit per stage. Depends on rbsi_pkg.
module rbsi_div (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [rbsi_pkg::CW:0]    num,
  input  rbsi_pkg::coord_t                den,
  output rbsi_pkg::coord_t                quo
);

  localparam int CW = rbsi_pkg::CW;
  localparam int FB = rbsi_pkg::FB;
  localparam int QB = rbsi_pkg::QB;
  localparam int NW = rbsi_pkg::NW;

  logic [CW:0]   nmag;
  logic [NW-1:0] nsh;
  logic [CW-1:0] dmag_in;

  assign nmag    = num[CW] ? (CW+1)'(-num) : num;
  assign nsh     = {nmag, FB'(0)};
  assign dmag_in = den[CW-1] ? CW'(-den) : den;

  logic [CW-1:0] rem  [0:QB];
  logic [QB-1:0] nl   [0:QB];
  logic [CW-1:0] dm   [0:QB];
  logic [QB-1:0] qq   [0:QB];
  logic          ovf  [0:QB];
  logic          neg  [0:QB];
  logic          zero [0:QB];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= CW'(nsh[NW-1:QB]);
      nl[0]   <= nsh[QB-1:0];
      dm[0]   <= dmag_in;
      qq[0]   <= '0;
      ovf[0]  <= CW'(nsh[NW-1:QB]) >= dmag_in;
      neg[0]  <= num[CW] ^ den[CW-1];
      zero[0] <= (num == '0);
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [CW:0] trial;
    logic        take;
    assign trial = {rem[k], nl[k][QB-1]};
    assign take  = trial >= {1'b0, dm[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= take ? CW'(trial - {1'b0, dm[k]}) : trial[CW-1:0];
        nl[k+1]   <= {nl[k][QB-2:0], 1'b0};
        dm[k+1]   <= dm[k];
        qq[k+1]   <= {qq[k][QB-2:0], take};
        ovf[k+1]  <= ovf[k];
        neg[k+1]  <= neg[k];
        zero[k+1] <= zero[k];
      end
    end
  end

  always_comb begin
    if (zero[QB]) quo = '0;
    else if (ovf[QB]) quo = neg[QB] ? rbsi_pkg::CMIN : rbsi_pkg::CMAX;
    else if (neg[QB]) quo = -$signed({1'b0, qq[QB]});
    else quo = $signed({1'b0, qq[QB]});
  end

endmodule
